@@ hdl/typed_stack_machine_alu_defines.svh @@
// Assertion macros shared by the stack machine RTL.
`ifndef TYPED_STACK_MACHINE_ALU_DEFINES_SVH
`define TYPED_STACK_MACHINE_ALU_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TSM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stack machine check failed");

// Next-cycle implication, disabled during reset.
`define TSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stack machine check failed");

`endif

@@ hdl/tsm_pkg.sv @@
// Shared types, instruction codes and decode for the stack machine.
package tsm_pkg;

  localparam int DEFAULT_STACK_DEPTH = 64;

  localparam logic [4:0] K_PUSH   = 5'd0;
  localparam logic [4:0] K_ADD    = 5'd1;
  localparam logic [4:0] K_SUB    = 5'd2;
  localparam logic [4:0] K_MUL    = 5'd3;
  localparam logic [4:0] K_DIVMOD = 5'd4;
  localparam logic [4:0] K_LT     = 5'd5;
  localparam logic [4:0] K_GT     = 5'd6;
  localparam logic [4:0] K_LE     = 5'd7;
  localparam logic [4:0] K_GE     = 5'd8;
  localparam logic [4:0] K_EQ     = 5'd9;
  localparam logic [4:0] K_NE     = 5'd10;
  localparam logic [4:0] K_SHR    = 5'd11;
  localparam logic [4:0] K_SHL    = 5'd12;
  localparam logic [4:0] K_OR     = 5'd13;
  localparam logic [4:0] K_AND    = 5'd14;
  localparam logic [4:0] K_NOT    = 5'd15;
  localparam logic [4:0] K_CASTB  = 5'd16;
  localparam logic [4:0] K_CASTI  = 5'd17;
  localparam logic [4:0] K_CASTP  = 5'd18;
  localparam logic [4:0] K_PRINT  = 5'd19;
  localparam logic [4:0] K_DUP    = 5'd20;
  localparam logic [4:0] K_DROP   = 5'd21;
  localparam logic [4:0] K_SWAP   = 5'd22;
  localparam logic [4:0] K_ROT    = 5'd23;
  localparam logic [4:0] K_OVER   = 5'd24;
  localparam logic [4:0] K_MAX    = 5'd25;

  localparam logic [1:0] TAG_INT  = 2'd0;
  localparam logic [1:0] TAG_BOOL = 2'd1;
  localparam logic [1:0] TAG_PTR  = 2'd2;
  localparam logic [1:0] TAG_ADDR = 2'd3;

  localparam logic [1:0] F_OK    = 2'd0;
  localparam logic [1:0] F_UNDER = 2'd1;
  localparam logic [1:0] F_OVER  = 2'd2;
  localparam logic [1:0] F_DIV0  = 2'd3;

  typedef struct packed {
    logic       legal;
    logic [1:0] need;
    logic       grow;
    logic [1:0] nwr;
    logic       is_md;
  } dec_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic       latch;
    logic       fault_ld;
    logic       div_flt;
    logic       rd_en;
    logic       cap;
    logic [1:0] idx;
    logic       md_start;
    logic       exec;
    logic       wr_en;
    logic       commit;
    logic       resp_ld;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [1:0] need;
    logic [1:0] nwr;
    logic       is_md;
    logic       stk_fault;
    logic       div_zero;
    logic       md_busy;
  } status_t;

  function automatic dec_t decode(input logic [4:0] kind);
    dec_t d;
    d = '0;
    unique case (kind)
      K_PUSH: begin
        d = '{legal: 1'b1, need: 2'd0, grow: 1'b1, nwr: 2'd1, is_md: 1'b0};
      end
      K_ADD, K_SUB, K_LT, K_GT, K_LE, K_GE, K_EQ, K_NE, K_SHR, K_SHL, K_OR, K_AND,
      K_MAX, K_OVER: begin
        d = '{legal: 1'b1, need: 2'd2, grow: (kind == K_OVER), nwr: 2'd1, is_md: 1'b0};
      end
      K_MUL: begin
        d = '{legal: 1'b1, need: 2'd2, grow: 1'b0, nwr: 2'd1, is_md: 1'b1};
      end
      K_DIVMOD: begin
        d = '{legal: 1'b1, need: 2'd2, grow: 1'b0, nwr: 2'd2, is_md: 1'b1};
      end
      K_NOT, K_CASTB, K_CASTI, K_CASTP: begin
        d = '{legal: 1'b1, need: 2'd1, grow: 1'b0, nwr: 2'd1, is_md: 1'b0};
      end
      K_PRINT, K_DROP: begin
        d = '{legal: 1'b1, need: 2'd1, grow: 1'b0, nwr: 2'd0, is_md: 1'b0};
      end
      K_DUP: begin
        d = '{legal: 1'b1, need: 2'd1, grow: 1'b1, nwr: 2'd1, is_md: 1'b0};
      end
      K_SWAP: begin
        d = '{legal: 1'b1, need: 2'd2, grow: 1'b0, nwr: 2'd2, is_md: 1'b0};
      end
      K_ROT: begin
        d = '{legal: 1'b1, need: 2'd3, grow: 1'b0, nwr: 2'd3, is_md: 1'b0};
      end
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

@@ hdl/typed_stack_machine_alu.sv @@
// Top level of the typed data-stack ALU: controller plus datapath.
//
// Usage: drive kind and immediate and raise start; the instruction is taken
// at the clock edge where start is high and busy is low. busy then stays high
// until the result is issued. Exactly one result per instruction appears on
// top_value, top_type, stack_nonempty, stack_depth, print_valid, print_value
// and fault for a single cycle, marked by done; the receiver has no way to
// stall it, and the result ports are valid only while done is high.
// The stack memory is read or written one entry per cycle, so the run time
// of an instruction is set by its stack accesses; it is shorter on a stack
// fault or a divide by zero, and longer for mul and divmod, which run bit by
// bit through a shared shift-add/subtract unit.
// A new instruction may be started in the cycle that done is high.
// Reset empties the stack (depth zero) and returns to idle; memory contents
// are not cleared and only entries below the depth are ever used.
module typed_stack_machine_alu #(
  parameter int STACK_DEPTH = tsm_pkg::DEFAULT_STACK_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [4:0]         kind,
  input  logic signed [63:0] immediate,
  output logic               done,
  output logic signed [63:0] top_value,
  output logic [1:0]         top_type,
  output logic               stack_nonempty,
  output logic [6:0]         stack_depth,
  output logic               print_valid,
  output logic signed [63:0] print_value,
  output logic [1:0]         fault
);

  tsm_pkg::cmd_t    cmd;
  tsm_pkg::status_t status;

  tsm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd),
    .status (status)
  );

  tsm_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .kind           (kind),
    .immediate      (immediate),
    .top_value      (top_value),
    .top_type       (top_type),
    .stack_nonempty (stack_nonempty),
    .stack_depth    (stack_depth),
    .print_valid    (print_valid),
    .print_value    (print_value),
    .fault          (fault)
  );

endmodule

@@ hdl/tsm_muldiv.sv @@
// Bit-serial 64-bit multiplier and unsigned restoring divider.
module tsm_muldiv (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        is_div,
  input  logic [63:0] op_a,
  input  logic [63:0] op_b,
  output logic        busy,
  output logic [63:0] prod,
  output logic [63:0] quo,
  output logic [63:0] rem
);

  logic [5:0]  cnt;
  logic        div_mode;
  logic [63:0] acc;
  logic [63:0] sh;
  logic [63:0] opb;
  logic [64:0] trial;

  assign trial = {acc, sh[63]} - {1'b0, opb};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      cnt      <= '0;
      div_mode <= is_div;
      acc      <= '0;
      sh       <= is_div ? op_a : op_b;
      opb      <= is_div ? op_b : op_a;
    end else if (busy) begin
      cnt <= cnt + 6'd1;
      if (cnt == 6'd63) busy <= 1'b0;
      if (div_mode) begin
        if (!trial[64]) begin
          acc <= trial[63:0];
          sh  <= {sh[62:0], 1'b1};
        end else begin
          acc <= {acc[62:0], sh[63]};
          sh  <= {sh[62:0], 1'b0};
        end
      end else begin
        if (sh[0]) acc <= acc + opb;
        opb <= {opb[62:0], 1'b0};
        sh  <= {1'b0, sh[63:1]};
      end
    end
  end

  assign prod = acc;
  assign quo  = sh;
  assign rem  = acc;

endmodule

@@ hdl/tsm_dp.sv @@
// Datapath: stack memory, operand and write registers, ALU and result registers.
module tsm_dp #(
  parameter int STACK_DEPTH = tsm_pkg::DEFAULT_STACK_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tsm_pkg::cmd_t         cmd,
  output tsm_pkg::status_t      status,
  input  logic [4:0]            kind,
  input  logic signed [63:0]    immediate,
  output logic signed [63:0]    top_value,
  output logic [1:0]            top_type,
  output logic                  stack_nonempty,
  output logic [6:0]            stack_depth,
  output logic                  print_valid,
  output logic signed [63:0]    print_value,
  output logic [1:0]            fault
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [65:0]    mem [STACK_DEPTH];
  logic [65:0]    rdata;

  logic [CW-1:0]  count;
  logic [CW-1:0]  nc;
  logic [4:0]     kind_r;
  logic [63:0]    imm_r;
  logic [63:0]    v1, v2, v3;
  logic [1:0]     t1, t2, t3;
  logic [AW-1:0]  wa [3];
  logic [63:0]    wv [3];
  logic [1:0]     wt [3];

  tsm_pkg::dec_t  dec;
  logic [CW:0]    grown;
  logic [1:0]     stk_code;
  logic [CW-1:0]  rd_n;
  logic [AW-1:0]  c0, cm1, cm2, cm3;
  logic [CW+6:0]  dext;

  logic [63:0]    alu_v;
  logic [1:0]     alu_t;
  logic [AW-1:0]  e_a [3];
  logic [63:0]    e_v [3];
  logic [1:0]     e_t [3];
  logic [CW-1:0]  e_nc;

  logic           md_busy;
  logic [63:0]    md_prod, md_quo, md_rem;
  logic [63:0]    mag_a, mag_b, q_fix, r_fix;

  assign dec   = tsm_pkg::decode(kind_r);
  assign grown = {1'b0, count} + (CW + 1)'(dec.grow);

  always_comb begin
    if (!dec.legal) stk_code = tsm_pkg::F_OK;
    else if (count < CW'(dec.need)) stk_code = tsm_pkg::F_UNDER;
    else if (grown > (CW + 1)'(STACK_DEPTH)) stk_code = tsm_pkg::F_OVER;
    else stk_code = tsm_pkg::F_OK;
  end

  assign status.need      = dec.need;
  assign status.nwr       = dec.nwr;
  assign status.is_md     = dec.is_md;
  assign status.stk_fault = (stk_code != tsm_pkg::F_OK);
  assign status.div_zero  = (kind_r == tsm_pkg::K_DIVMOD) && (v1 == 64'd0);
  assign status.md_busy   = md_busy;

  assign rd_n = count - CW'(cmd.idx);
  assign c0   = count[AW-1:0];
  assign cm1  = c0 - AW'(1);
  assign cm2  = c0 - AW'(2);
  assign cm3  = c0 - AW'(3);
  assign dext = {7'd0, count};

  // v2 is the second entry (a), v1 the top (b).
  always_comb begin
    alu_t = tsm_pkg::TAG_INT;
    unique case (kind_r)
      tsm_pkg::K_ADD: alu_v = v2 + v1;
      tsm_pkg::K_SUB: alu_v = v2 - v1;
      tsm_pkg::K_LT: begin
        alu_v = {63'd0, $signed(v2) < $signed(v1)};
        alu_t = tsm_pkg::TAG_BOOL;
      end
      tsm_pkg::K_GT: begin
        alu_v = {63'd0, $signed(v2) > $signed(v1)};
        alu_t = tsm_pkg::TAG_BOOL;
      end
      tsm_pkg::K_LE: begin
        alu_v = {63'd0, $signed(v2) <= $signed(v1)};
        alu_t = tsm_pkg::TAG_BOOL;
      end
      tsm_pkg::K_GE: begin
        alu_v = {63'd0, $signed(v2) >= $signed(v1)};
        alu_t = tsm_pkg::TAG_BOOL;
      end
      tsm_pkg::K_EQ: begin
        alu_v = {63'd0, v2 == v1};
        alu_t = tsm_pkg::TAG_BOOL;
      end
      tsm_pkg::K_NE: begin
        alu_v = {63'd0, v2 != v1};
        alu_t = tsm_pkg::TAG_BOOL;
      end
      tsm_pkg::K_SHR: alu_v = $unsigned($signed(v2) >>> v1[5:0]);
      tsm_pkg::K_SHL: alu_v = v2 << v1[5:0];
      tsm_pkg::K_OR:  alu_v = v2 | v1;
      tsm_pkg::K_AND: alu_v = v2 & v1;
      tsm_pkg::K_MAX: alu_v = ($signed(v2) < $signed(v1)) ? v1 : v2;
      default:        alu_v = 64'd0;
    endcase
  end

  assign mag_a = v2[63] ? (64'd0 - v2) : v2;
  assign mag_b = v1[63] ? (64'd0 - v1) : v1;
  assign q_fix = (v2[63] ^ v1[63]) ? (64'd0 - md_quo) : md_quo;
  assign r_fix = v2[63] ? (64'd0 - md_rem) : md_rem;

  tsm_muldiv u_md (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.md_start),
    .is_div (kind_r == tsm_pkg::K_DIVMOD),
    .op_a   ((kind_r == tsm_pkg::K_DIVMOD) ? mag_a : v2),
    .op_b   ((kind_r == tsm_pkg::K_DIVMOD) ? mag_b : v1),
    .busy   (md_busy),
    .prod   (md_prod),
    .quo    (md_quo),
    .rem    (md_rem)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e_a[i] = c0;
      e_v[i] = 64'd0;
      e_t[i] = tsm_pkg::TAG_INT;
    end
    e_nc = count;
    unique case (kind_r)
      tsm_pkg::K_PUSH: begin
        e_v[0] = imm_r;
        e_nc   = count + CW'(1);
      end
      tsm_pkg::K_ADD, tsm_pkg::K_SUB, tsm_pkg::K_LT, tsm_pkg::K_GT, tsm_pkg::K_LE,
      tsm_pkg::K_GE, tsm_pkg::K_EQ, tsm_pkg::K_NE, tsm_pkg::K_SHR, tsm_pkg::K_SHL,
      tsm_pkg::K_OR, tsm_pkg::K_AND, tsm_pkg::K_MAX: begin
        e_a[0] = cm2;
        e_v[0] = alu_v;
        e_t[0] = alu_t;
        e_nc   = count - CW'(1);
      end
      tsm_pkg::K_MUL: begin
        e_a[0] = cm2;
        e_v[0] = md_prod;
        e_nc   = count - CW'(1);
      end
      tsm_pkg::K_DIVMOD: begin
        e_a[0] = cm2;
        e_v[0] = q_fix;
        e_a[1] = cm1;
        e_v[1] = r_fix;
      end
      tsm_pkg::K_NOT: begin
        e_a[0] = cm1;
        e_v[0] = ~v1;
      end
      tsm_pkg::K_CASTB: begin
        e_a[0] = cm1;
        e_v[0] = {63'd0, (v1 != 64'd0) && !v1[63]};
        e_t[0] = tsm_pkg::TAG_BOOL;
      end
      tsm_pkg::K_CASTI: begin
        e_a[0] = cm1;
        e_v[0] = v1;
      end
      tsm_pkg::K_CASTP: begin
        e_a[0] = cm1;
        e_v[0] = v1;
        e_t[0] = tsm_pkg::TAG_PTR;
      end
      tsm_pkg::K_PRINT, tsm_pkg::K_DROP: e_nc = count - CW'(1);
      tsm_pkg::K_DUP: begin
        e_v[0] = v1;
        e_t[0] = t1;
        e_nc   = count + CW'(1);
      end
      tsm_pkg::K_SWAP: begin
        e_a[0] = cm2;
        e_v[0] = v1;
        e_t[0] = t1;
        e_a[1] = cm1;
        e_v[1] = v2;
        e_t[1] = t2;
      end
      tsm_pkg::K_ROT: begin
        e_a[0] = cm3;
        e_v[0] = v2;
        e_t[0] = t2;
        e_a[1] = cm2;
        e_v[1] = v1;
        e_t[1] = t1;
        e_a[2] = cm1;
        e_v[2] = v3;
        e_t[2] = t3;
      end
      tsm_pkg::K_OVER: begin
        e_v[0] = v2;
        e_t[0] = t2;
        e_nc   = count + CW'(1);
      end
      default: e_nc = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[wa[cmd.idx]] <= {wt[cmd.idx], wv[cmd.idx]};
    if (cmd.rd_en) rdata <= mem[rd_n[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count          <= '0;
      fault          <= tsm_pkg::F_OK;
      print_valid    <= 1'b0;
      stack_nonempty <= 1'b0;
      stack_depth    <= '0;
    end else begin
      if (cmd.latch) begin
        kind_r      <= kind;
        imm_r       <= immediate;
        print_valid <= 1'b0;
        print_value <= '0;
      end
      if (cmd.fault_ld) fault <= stk_code;
      if (cmd.div_flt) fault <= tsm_pkg::F_DIV0;
      if (cmd.cap) begin
        unique case (cmd.idx)
          2'd1: {t1, v1} <= rdata;
          2'd2: {t2, v2} <= rdata;
          2'd3: {t3, v3} <= rdata;
          default: ;
        endcase
      end
      if (cmd.exec) begin
        for (int i = 0; i < 3; i++) begin
          wa[i] <= e_a[i];
          wv[i] <= e_v[i];
          wt[i] <= e_t[i];
        end
        nc <= e_nc;
        if (kind_r == tsm_pkg::K_PRINT) begin
          print_valid <= 1'b1;
          print_value <= v1;
        end
      end
      if (cmd.commit) count <= nc;
      if (cmd.resp_ld) begin
        stack_nonempty <= (count != '0);
        stack_depth    <= dext[6:0];
        if (count != '0) begin
          top_value <= rdata[63:0];
          top_type  <= rdata[65:64];
        end else begin
          top_value <= '1;
          top_type  <= tsm_pkg::TAG_ADDR;
        end
      end
    end
  end

endmodule

@@ hdl/tsm_ctrl.sv @@
// Controller: sequences reads, execution, writes and the response of one instruction.
`include "typed_stack_machine_alu_defines.svh"

module tsm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output tsm_pkg::cmd_t     cmd,
  input  tsm_pkg::status_t  status
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_RD, S_CAP, S_EXEC, S_MD_WAIT, S_LOAD, S_WR, S_COMMIT,
    S_TOP_RD, S_TOP_CAP
  } state_t;

  state_t     state;
  logic [1:0] k;

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:    cmd.latch = start && !busy;
      S_CHECK:   cmd.fault_ld = 1'b1;
      S_RD: begin
        cmd.rd_en = 1'b1;
        cmd.idx   = k;
      end
      S_CAP: begin
        cmd.cap = 1'b1;
        cmd.idx = k;
      end
      S_EXEC: begin
        cmd.div_flt  = status.div_zero;
        cmd.md_start = !status.div_zero && status.is_md;
        cmd.exec     = !status.div_zero && !status.is_md;
      end
      S_MD_WAIT: ;
      S_LOAD:    cmd.exec = 1'b1;
      S_WR: begin
        cmd.wr_en = 1'b1;
        cmd.idx   = k;
      end
      S_COMMIT:  cmd.commit = 1'b1;
      S_TOP_RD: begin
        cmd.rd_en = 1'b1;
        cmd.idx   = 2'd1;
      end
      S_TOP_CAP: cmd.resp_ld = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
      k     <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start && !busy) begin
            busy  <= 1'b1;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          k <= 2'd1;
          if (status.stk_fault) state <= S_TOP_RD;
          else if (status.need == 2'd0) state <= S_EXEC;
          else state <= S_RD;
        end
        S_RD: state <= S_CAP;
        S_CAP: begin
          if (k == status.need) begin
            state <= S_EXEC;
          end else begin
            k     <= k + 2'd1;
            state <= S_RD;
          end
        end
        S_EXEC: begin
          k <= '0;
          if (status.div_zero) state <= S_TOP_RD;
          else if (status.is_md) state <= S_MD_WAIT;
          else if (status.nwr == 2'd0) state <= S_COMMIT;
          else state <= S_WR;
        end
        S_MD_WAIT: if (!status.md_busy) state <= S_LOAD;
        S_LOAD: state <= S_WR;
        S_WR: begin
          if (k == status.nwr - 2'd1) state <= S_COMMIT;
          else k <= k + 2'd1;
        end
        S_COMMIT: state <= S_TOP_RD;
        S_TOP_RD: state <= S_TOP_CAP;
        S_TOP_CAP: begin
          done  <= 1'b1;
          busy  <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TSM_ASSERT_IMPLY(a_done_idle, clk, rst, done, !busy)
  `TSM_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)
  `TSM_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy && !done)

endmodule

@@ sim/typed_stack_machine_alu_test.sv @@
// Self-checking testbench for the typed stack machine ALU: directed and random instruction stream vs. predictor.
module typed_stack_machine_alu_test;

  localparam int DEPTH = 64;

  typedef struct packed {
    logic [4:0]  kind;
    logic [63:0] imm;
  } instr_t;

  typedef struct packed {
    logic [63:0] top_value;
    logic [1:0]  top_type;
    logic        nonempty;
    logic [6:0]  depth;
    logic        pvalid;
    logic [63:0] pvalue;
    logic [1:0]  fault;
  } status_word_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [4:0]         kind = '0;
  logic signed [63:0] immediate = '0;
  logic               done;
  logic signed [63:0] top_value;
  logic [1:0]         top_type;
  logic               stack_nonempty;
  logic [6:0]         stack_depth;
  logic               print_valid;
  logic signed [63:0] print_value;
  logic [1:0]         fault;

  instr_t       pending_instrs[$];
  status_word_t expected_status[$];
  logic [63:0]  model_vals[DEPTH];
  logic [1:0]   model_tags[DEPTH];
  int           model_count;
  int           errors = 0;
  int           sent = 0;
  int           checked = 0;
  int           fault_seen[4];
  int           gap = 0;

  typed_stack_machine_alu #(.STACK_DEPTH(DEPTH)) i_dut (.*);

  always #6 clk = ~clk;

  function automatic logic slt(logic [63:0] a, logic [63:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic void put(int i, logic [63:0] v, logic [1:0] t);
    model_vals[i] = v;
    model_tags[i] = t;
  endfunction

  // Execute one instruction on the shadow stack and return the expected status.
  function automatic status_word_t execute_instr(instr_t in);
    status_word_t s;
    int n, need, grow;
    logic [63:0] a, b, v, r, ma, mb, q, rm;
    logic [1:0] t, at, bt, vt;
    s = '0;
    n = model_count;
    need = 0;
    grow = 0;
    case (in.kind)
      tsm_pkg::K_PUSH: grow = 1;
      tsm_pkg::K_DUP: begin need = 1; grow = 1; end
      tsm_pkg::K_OVER: begin need = 2; grow = 1; end
      tsm_pkg::K_ROT: need = 3;
      tsm_pkg::K_NOT, tsm_pkg::K_CASTB, tsm_pkg::K_CASTI, tsm_pkg::K_CASTP,
      tsm_pkg::K_PRINT, tsm_pkg::K_DROP: need = 1;
      default: need = (in.kind <= tsm_pkg::K_MAX) ? 2 : 0;
    endcase
    if (in.kind > tsm_pkg::K_MAX) begin
    end else if (n < need) begin
      s.fault = tsm_pkg::F_UNDER;
    end else if (n + grow > DEPTH) begin
      s.fault = tsm_pkg::F_OVER;
    end else if (in.kind == tsm_pkg::K_PUSH) begin
      put(n, in.imm, tsm_pkg::TAG_INT);
      model_count = n + 1;
    end else if (in.kind <= tsm_pkg::K_AND || in.kind == tsm_pkg::K_MAX) begin
      a = model_vals[n-2];
      b = model_vals[n-1];
      r = '0;
      t = tsm_pkg::TAG_INT;
      case (in.kind)
        tsm_pkg::K_ADD: r = a + b;
        tsm_pkg::K_SUB: r = a - b;
        tsm_pkg::K_MUL: r = a * b;
        tsm_pkg::K_DIVMOD: begin
          if (b == 0) s.fault = tsm_pkg::F_DIV0;
          else begin
            ma = a[63] ? -a : a;
            mb = b[63] ? -b : b;
            q = ma / mb;
            rm = ma % mb;
            if (a[63] ^ b[63]) q = -q;
            if (a[63]) rm = -rm;
            put(n - 2, q, tsm_pkg::TAG_INT);
            put(n - 1, rm, tsm_pkg::TAG_INT);
          end
        end
        tsm_pkg::K_LT: begin r = 64'(slt(a, b)); t = tsm_pkg::TAG_BOOL; end
        tsm_pkg::K_GT: begin r = 64'(slt(b, a)); t = tsm_pkg::TAG_BOOL; end
        tsm_pkg::K_LE: begin r = 64'(!slt(b, a)); t = tsm_pkg::TAG_BOOL; end
        tsm_pkg::K_GE: begin r = 64'(!slt(a, b)); t = tsm_pkg::TAG_BOOL; end
        tsm_pkg::K_EQ: begin r = 64'(a == b); t = tsm_pkg::TAG_BOOL; end
        tsm_pkg::K_NE: begin r = 64'(a != b); t = tsm_pkg::TAG_BOOL; end
        tsm_pkg::K_SHR: r = $signed(a) >>> b[5:0];
        tsm_pkg::K_SHL: r = a << b[5:0];
        tsm_pkg::K_OR: r = a | b;
        tsm_pkg::K_AND: r = a & b;
        default: r = slt(a, b) ? b : a;
      endcase
      if (in.kind != tsm_pkg::K_DIVMOD) begin
        put(n - 2, r, t);
        model_count = n - 1;
      end
    end else begin
      v = model_vals[n-1];
      vt = model_tags[n-1];
      case (in.kind)
        tsm_pkg::K_NOT: put(n - 1, ~v, tsm_pkg::TAG_INT);
        tsm_pkg::K_CASTB:
          put(n - 1, (v != 0 && !v[63]) ? 64'd1 : 64'd0, tsm_pkg::TAG_BOOL);
        tsm_pkg::K_CASTI: put(n - 1, v, tsm_pkg::TAG_INT);
        tsm_pkg::K_CASTP: put(n - 1, v, tsm_pkg::TAG_PTR);
        tsm_pkg::K_PRINT: begin s.pvalid = 1'b1; s.pvalue = v; model_count = n - 1; end
        tsm_pkg::K_DUP: begin put(n, v, vt); model_count = n + 1; end
        tsm_pkg::K_DROP: model_count = n - 1;
        tsm_pkg::K_SWAP: begin
          a = model_vals[n-2];
          at = model_tags[n-2];
          put(n - 2, v, vt);
          put(n - 1, a, at);
        end
        tsm_pkg::K_ROT: begin
          a = model_vals[n-3];
          at = model_tags[n-3];
          b = model_vals[n-2];
          bt = model_tags[n-2];
          put(n - 3, b, bt);
          put(n - 2, v, vt);
          put(n - 1, a, at);
        end
        default: begin put(n, model_vals[n-2], model_tags[n-2]); model_count = n + 1; end
      endcase
    end
    n = model_count;
    if (n > 0) begin
      s.top_value = model_vals[n-1];
      s.top_type = model_tags[n-1];
      s.nonempty = 1'b1;
    end else begin
      s.top_value = '1;
      s.top_type = tsm_pkg::TAG_ADDR;
    end
    s.depth = n[6:0];
    return s;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch at result %0d: %s got %h want %h", checked, what, got, want);
  endtask

  function automatic logic [63:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return -64'($urandom_range(0, 9));
      3: return 64'($urandom_range(0, 70));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic instr_t mk(logic [4:0] k, logic [63:0] v = '0);
    instr_t i;
    i.kind = k;
    i.imm = v;
    return i;
  endfunction

  task automatic add_instr(instr_t i);
    pending_instrs = {pending_instrs, i};
  endtask

  // Driver: hold start until the transaction is taken, predict it, then wait a random gap.
  always @(posedge clk) begin
    instr_t taken;
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      taken = pending_instrs.pop_front();
      expected_status = {expected_status, execute_instr(taken)};
      sent++;
      gap = $urandom_range(0, 11);
      if (gap == 0 && pending_instrs.size() > 0) begin
        kind <= pending_instrs[0].kind;
        immediate <= pending_instrs[0].imm;
      end else begin
        start <= 1'b0;
      end
    end else if (!start) begin
      if (gap > 1) gap = gap - 1;
      else if (pending_instrs.size() > 0) begin
        gap = 0;
        start <= 1'b1;
        kind <= pending_instrs[0].kind;
        immediate <= pending_instrs[0].imm;
      end
    end
  end

  // Monitor: compare each strobed result against the oldest expectation.
  always @(posedge clk) begin
    status_word_t e;
    if (!rst && done) begin
      if (expected_status.size() == 0) begin
        errors++;
        $display("unexpected result with nothing outstanding");
      end else begin
        e = expected_status.pop_front();
        if (top_value !== e.top_value) report("top_value", top_value, e.top_value);
        if (top_type !== e.top_type)
          report("top_type", 64'(top_type), 64'(e.top_type));
        if (stack_nonempty !== e.nonempty)
          report("stack_nonempty", 64'(stack_nonempty), 64'(e.nonempty));
        if (stack_depth !== e.depth)
          report("stack_depth", 64'(stack_depth), 64'(e.depth));
        if (print_valid !== e.pvalid)
          report("print_valid", 64'(print_valid), 64'(e.pvalid));
        if (print_value !== e.pvalue) report("print_value", print_value, e.pvalue);
        if (fault !== e.fault) report("fault", 64'(fault), 64'(e.fault));
        fault_seen[e.fault]++;
        checked++;
      end
    end
  end

  initial begin
    int target;
    int d;
    model_count = 0;
    // Directed: underflow on empty, extremes, a subset of the operations, illegal codes, division corners.
    add_instr(mk(tsm_pkg::K_DROP));
    add_instr(mk(tsm_pkg::K_ADD));
    add_instr(mk(tsm_pkg::K_PUSH, 64'h8000_0000_0000_0000));
    add_instr(mk(tsm_pkg::K_SWAP));
    add_instr(mk(tsm_pkg::K_PUSH, '1));
    add_instr(mk(tsm_pkg::K_DIVMOD));
    add_instr(mk(tsm_pkg::K_PUSH, 64'd0));
    add_instr(mk(tsm_pkg::K_DIVMOD));
    add_instr(mk(tsm_pkg::K_PUSH, 64'h7fff_ffff_ffff_ffff));
    add_instr(mk(tsm_pkg::K_PUSH, -64'd7));
    add_instr(mk(tsm_pkg::K_ROT));
    add_instr(mk(tsm_pkg::K_PUSH, 64'd2));
    add_instr(mk(tsm_pkg::K_DIVMOD));
    add_instr(mk(tsm_pkg::K_CASTB));
    add_instr(mk(tsm_pkg::K_OVER));
    add_instr(mk(tsm_pkg::K_CASTP));
    add_instr(mk(tsm_pkg::K_DUP));
    add_instr(mk(tsm_pkg::K_PRINT));
    add_instr(mk(5'd31));
    add_instr(mk(5'd26));
    add_instr(mk(tsm_pkg::K_PUSH, 64'd65));
    add_instr(mk(tsm_pkg::K_SHL));
    // Fill to overflow, then random work around full and empty.
    for (int i = 0; i < DEPTH + 2; i++) add_instr(mk(tsm_pkg::K_PUSH, rand_value()));
    add_instr(mk(tsm_pkg::K_DUP));
    add_instr(mk(tsm_pkg::K_OVER));
    target = 500;
    d = DEPTH;
    while (pending_instrs.size() < target - 80) begin
      logic [4:0] k;
      if (d < 3 || ($urandom_range(0, 3) == 0 && d < DEPTH)) k = tsm_pkg::K_PUSH;
      else if ($urandom_range(0, 40) == 0) k = 5'($urandom_range(26, 31));
      else k = 5'($urandom_range(1, 25));
      add_instr(mk(k, rand_value()));
      if (k == tsm_pkg::K_PUSH || k == tsm_pkg::K_DUP || k == tsm_pkg::K_OVER)
        d = (d < DEPTH) ? d + 1 : d;
      else if ((k <= tsm_pkg::K_AND && k != tsm_pkg::K_DIVMOD) || k == tsm_pkg::K_MAX ||
               k == tsm_pkg::K_PRINT || k == tsm_pkg::K_DROP)
        d = d - 1;
    end
    for (int i = 0; i < 80; i++) add_instr(mk(tsm_pkg::K_DROP));
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    wait (pending_instrs.size() == 0);
    wait (expected_status.size() == 0);
    repeat (100) @(posedge clk);
    $display("ran %0d instructions, checked %0d results", sent, checked);
    $display("faults: ok %0d underflow %0d overflow %0d div-by-zero %0d",
             fault_seen[0], fault_seen[1], fault_seen[2], fault_seen[3]);
    if (errors == 0 && expected_status.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #12000000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
